FILE: sv/ppdh_pkg.sv
// Shared types and constants for the planar position density histogram.
`default_nettype none
package ppdh_pkg;

    localparam int POS_W       = 32;
    localparam int CFG_W       = 31;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int FIELD_IDX_W = 8;
    localparam int POP_FIELD_W = 2;
    localparam int OUT_COUNT_W = 32;
    localparam int DIV_W       = 32;

    localparam logic [CFG_W-1:0] HALF_BOX_RST  = 31'd6553600;
    localparam logic [CFG_W-1:0] CELL_SIZE_RST = 31'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BOX  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 4'd1;

    localparam logic CMD_BIN  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [POS_W-1:0]        x_position;
        logic [POS_W-1:0]        y_position;
        logic [POP_FIELD_W-1:0]  population;
        logic [FIELD_IDX_W-1:0]  read_column;
        logic [FIELD_IDX_W-1:0]  read_row;
    } ppdh_in_t;

    typedef struct packed {
        logic                    binned;
        logic [FIELD_IDX_W-1:0]  column;
        logic [FIELD_IDX_W-1:0]  row;
        logic [OUT_COUNT_W-1:0]  count;
    } ppdh_out_t;

    typedef struct packed {
        logic req;
        logic inc;
    } ppdh_store_ctl_t;

endpackage
`default_nettype wire

FILE: sv/ppdh_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module ppdh_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [ppdh_pkg::DIV_W-1:0]  dividend,
    input  wire logic [ppdh_pkg::CFG_W-1:0]  divisor,
    output logic                             done,
    output logic [ppdh_pkg::DIV_W-1:0]       quotient,
    output logic [ppdh_pkg::CFG_W-1:0]       remainder
);
    import ppdh_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [CFG_W-1:0] rem_reg, rem_next;
    logic [CFG_W-1:0] divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [CFG_W:0]   rem_shift;
    logic [CFG_W+1:0] diff;
    logic             ge;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        diff      = {1'b0, rem_shift} - {2'b0, divisor_reg};
        ge        = ~diff[CFG_W+1];
        rem_next  = ge ? diff[CFG_W-1:0] : rem_shift[CFG_W-1:0];
        quo_next  = {quo_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            cnt_reg     <= CNT_W'(DIV_W - 1);
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

FILE: sv/ppdh_store.sv
// Bin count memory with clearing sweep, plain reads and saturating read-modify-write.
`default_nettype none
module ppdh_store #(
    parameter int AW          = 18,
    parameter int DEPTH       = 196608,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ppdh_pkg::ppdh_store_ctl_t       ctl,
    input  wire logic [AW-1:0]                   addr,
    output logic                                 ready,
    output logic                                 resp_valid,
    output logic [COUNT_WIDTH-1:0]               resp_count
);
    import ppdh_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];

    logic                   clr_active_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic                   pend_reg;
    logic                   pend_inc_reg;
    logic [AW-1:0]          addr_hold_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   resp_valid_reg;
    logic [COUNT_WIDTH-1:0] resp_count_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] sat_count;

    always_comb begin
        sat_count = (&rd_data_reg) ? rd_data_reg : rd_data_reg + 1'b1;
        mem_we    = clr_active_reg || (pend_reg && pend_inc_reg);
        mem_waddr = clr_active_reg ? clr_addr_reg : addr_hold_reg;
        mem_wdata = clr_active_reg ? '0 : sat_count;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.req) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.req) begin
            addr_hold_reg <= addr;
            pend_inc_reg  <= ctl.inc;
        end
        if (pend_reg) begin
            resp_count_reg <= pend_inc_reg ? sat_count : rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            pend_reg       <= 1'b0;
            resp_valid_reg <= 1'b0;
        end else begin
            pend_reg       <= ctl.req;
            resp_valid_reg <= pend_reg;
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    assign ready      = ~clr_active_reg;
    assign resp_valid = resp_valid_reg;
    assign resp_count = resp_count_reg;

endmodule
`default_nettype wire

FILE: sv/planar_position_density_histogram.sv
// One beat at a time: s_ready stays low from acceptance until its result is loaded into
// the output register; in-box bin beats pass through the two 32-step serial dividers (one
// quotient bit per cycle). Reset: synchronous, active low; the bin memory is then swept
// to zero, one entry a cycle, over all POPULATIONS * 4**clog2(GRID_SIDE) entries
// (196608 by default), with s_ready low.
// Configuration writes are taken at any time out of reset, including during the sweep.
`default_nettype none
module planar_position_density_histogram #(
    parameter int GRID_SIDE   = 256,
    parameter int POPULATIONS = 3,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire ppdh_pkg::ppdh_in_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output ppdh_pkg::ppdh_out_t                      m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ppdh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ppdh_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ppdh_pkg::*;

    localparam int IW     = $clog2(GRID_SIDE);
    localparam int POP_AW = (POPULATIONS > 1) ? $clog2(POPULATIONS) : 1;
    localparam int AW     = POP_AW + 2 * IW;
    localparam int DEPTH  = POPULATIONS << (2 * IW);
    localparam int Q_W    = DIV_W + 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDCHK = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_TEST  = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_ROUND = 4'd5;
    localparam logic [3:0] ST_RANGE = 4'd6;
    localparam logic [3:0] ST_WAIT  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]        state_reg, state_next;
    ppdh_in_t          in_reg;
    logic [CFG_W-1:0]  hb_reg;
    logic [CFG_W-1:0]  cs_reg;
    logic [POS_W:0]    ax_reg, ay_reg, lim_reg;
    logic [DIV_W-1:0]  ux_reg, uy_reg;
    logic [Q_W-1:0]    qx_reg, qy_reg;
    ppdh_out_t         res_reg;
    logic              m_valid_reg;
    ppdh_out_t         m_data_reg;

    logic              accept;
    logic              out_free;
    logic              in_box;
    logic              pop_ok;
    logic              rd_ok;
    logic              bin_ok;
    logic              round_x, round_y;
    logic [POS_W:0]    xs, ys;
    logic [POP_AW-1:0] pop_sel;

    ppdh_store_ctl_t        store_ctl;
    logic [AW-1:0]          store_addr;
    logic                   store_ready;
    logic                   store_resp_valid;
    logic [COUNT_WIDTH-1:0] store_resp_count;
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] count_ext;

    logic              div_start;
    logic              dx_done, dy_done;
    logic [DIV_W-1:0]  qx_div, qy_div;
    logic [CFG_W-1:0]  rx_div, ry_div;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && store_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = ~m_valid_reg || m_ready;

    always_comb begin
        xs      = {in_reg.x_position[POS_W-1], in_reg.x_position};
        ys      = {in_reg.y_position[POS_W-1], in_reg.y_position};
        in_box  = (cs_reg != '0) && ($signed(ax_reg) < $signed(lim_reg))
                  && ($signed(ay_reg) < $signed(lim_reg));
        pop_ok  = 4'(in_reg.population) < 4'(POPULATIONS);
        rd_ok   = (11'(in_reg.read_column) < 11'(GRID_SIDE))
                  && (11'(in_reg.read_row) < 11'(GRID_SIDE)) && pop_ok;
        bin_ok  = (qx_reg < Q_W'(GRID_SIDE)) && (qy_reg < Q_W'(GRID_SIDE)) && pop_ok;
        round_x = {rx_div, 1'b0} > {1'b0, cs_reg};
        round_y = {ry_div, 1'b0} > {1'b0, cs_reg};
        pop_sel = POP_AW'(in_reg.population);
        count_ext = {{OUT_COUNT_W{1'b0}}, store_resp_count};
        div_start = (state_reg == ST_TEST) && in_box;

        store_ctl.req = ((state_reg == ST_RDCHK) && rd_ok)
                        || ((state_reg == ST_RANGE) && bin_ok);
        store_ctl.inc = (state_reg == ST_RANGE);
        if (state_reg == ST_RANGE) begin
            store_addr = {pop_sel, IW'(qx_reg), IW'(qy_reg)};
        end else begin
            store_addr = {pop_sel, IW'(in_reg.read_column), IW'(in_reg.read_row)};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_data.command == CMD_READ) ? ST_RDCHK : ST_PREP;
                end
            end
            ST_RDCHK: state_next = rd_ok ? ST_WAIT : ST_DONE;
            ST_PREP:  state_next = ST_TEST;
            ST_TEST:  state_next = in_box ? ST_DIV : ST_DONE;
            ST_DIV: begin
                if (dx_done && dy_done) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: state_next = ST_RANGE;
            ST_RANGE: state_next = bin_ok ? ST_WAIT : ST_DONE;
            ST_WAIT: begin
                if (store_resp_valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        case (state_reg)
            ST_RDCHK: begin
                res_reg.binned <= 1'b0;
                res_reg.column <= in_reg.read_column;
                res_reg.row    <= in_reg.read_row;
                res_reg.count  <= '0;
            end
            ST_PREP: begin
                ax_reg  <= xs[POS_W] ? -xs : xs;
                ay_reg  <= ys[POS_W] ? -ys : ys;
                lim_reg <= {2'b0, hb_reg} - {2'b0, cs_reg};
                ux_reg  <= in_reg.x_position + DIV_W'(hb_reg);
                uy_reg  <= in_reg.y_position + DIV_W'(hb_reg);
            end
            ST_TEST: begin
                if (!in_box) begin
                    res_reg <= '0;
                end
            end
            ST_ROUND: begin
                qx_reg <= {1'b0, qx_div} + Q_W'(round_x);
                qy_reg <= {1'b0, qy_div} + Q_W'(round_y);
            end
            ST_RANGE: begin
                if (bin_ok) begin
                    res_reg.binned <= 1'b1;
                    res_reg.column <= qx_reg[FIELD_IDX_W-1:0];
                    res_reg.row    <= qy_reg[FIELD_IDX_W-1:0];
                end else begin
                    res_reg <= '0;
                end
            end
            ST_WAIT: begin
                if (store_resp_valid) begin
                    res_reg.count <= count_ext[OUT_COUNT_W-1:0];
                end
            end
            default: ;
        endcase
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            hb_reg      <= HALF_BOX_RST;
            cs_reg      <= CELL_SIZE_RST;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_HALF_BOX:  hb_reg <= cfg_data[CFG_W-1:0];
                    CFG_CELL_SIZE: cs_reg <= cfg_data[CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ppdh_div u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (ux_reg),
        .divisor   (cs_reg),
        .done      (dx_done),
        .quotient  (qx_div),
        .remainder (rx_div)
    );

    ppdh_div u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (uy_reg),
        .divisor   (cs_reg),
        .done      (dy_done),
        .quotient  (qy_div),
        .remainder (ry_div)
    );

    ppdh_store #(
        .AW          (AW),
        .DEPTH       (DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (store_ctl),
        .addr       (store_addr),
        .ready      (store_ready),
        .resp_valid (store_resp_valid),
        .resp_count (store_resp_count)
    );

endmodule
`default_nettype wire

FILE: sv/ppdh_checker.sv
// Port-level checker for the histogram, bound to the top level.
`default_nettype none
module ppdh_checker #(
    parameter int COUNT_WIDTH = 32
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire ppdh_pkg::ppdh_out_t  m_data
);
    import ppdh_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // memory sweep keeps the input closed right after reset
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open straight after reset");

    // one beat in flight at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while one is in flight");

    // an incremented bin never reports zero
    a_binned_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.binned |-> (COUNT_WIDTH > OUT_COUNT_W) || (m_data.count != '0))
        else $error("binned beat with zero count");

endmodule

bind planar_position_density_histogram ppdh_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_ppdh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the planar position density histogram: directed table, then random beats.
`timescale 1ns / 1ps

module testbench;
    import ppdh_pkg::*;

    localparam int     GRID             = 256;
    localparam int     NUM_POPS         = 3;
    localparam int     RANDOM_PER_PHASE = 72;
    localparam int     PLAN_LEN         = 8;
    localparam int     TAIL_CYCLES      = 60;
    localparam int     RECENT_DEPTH     = 64;
    localparam longint RUN_LIMIT_NS     = 64'd20_000_000;
    localparam longint POS_MAX          = 64'sd2147483647;
    localparam longint POS_MIN          = -POS_MAX - 1;
    localparam bit     TYPED            = 1'b1;
    localparam bit     PREDICTED        = 1'b0;

    typedef struct {
        ppdh_in_t  beat;
        bit        typed;
        ppdh_out_t result;
    } stim_row_t;

    typedef struct packed {
        logic [POP_FIELD_W-1:0] pop;
        logic [FIELD_IDX_W-1:0] col;
        logic [FIELD_IDX_W-1:0] row;
    } bin_addr_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    ppdh_in_t              s_data    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire                   cfg_ready;
    ppdh_out_t             m_data;

    // model of the block
    logic [CFG_W-1:0]       box_half  = HALF_BOX_RST;
    logic [CFG_W-1:0]       cell_edge = CELL_SIZE_RST;
    bit [OUT_COUNT_W-1:0]   bin_store [NUM_POPS][GRID][GRID];
    bin_addr_t              recent_hits [$];
    ppdh_out_t              expected_results [$];
    stim_row_t              directed_rows [$];

    bit [CFG_W-1:0] box_plan  [PLAN_LEN] = '{31'd13107200, 31'h7FFFFFFF, 31'd1,
                                             31'h7FFFFFFF, 31'h7FFFFFFF, 31'd300,
                                             31'd6553600, 31'd6553600};
    bit [CFG_W-1:0] cell_plan [PLAN_LEN] = '{31'd32768, 31'd1, 31'd1,
                                             31'h7FFFFFFF, 31'h00800000, 31'd3,
                                             31'd0, 31'd65536};

    bit          no_idle    = 1'b0;
    int unsigned stall_left = 0;
    int          errors          = 0;
    int          beats_sent      = 0;
    int          reads_sent      = 0;
    int          results_checked = 0;
    int          bins_seen       = 0;
    int          settings_run    = 1;

    planar_position_density_histogram #(
        .GRID_SIDE   (GRID),
        .POPULATIONS (NUM_POPS),
        .COUNT_WIDTH (OUT_COUNT_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint unsigned grid_index(input longint pos);
        longint unsigned shifted, quot, rem;
        shifted = pos + longint'(box_half);
        quot    = shifted / cell_edge;
        rem     = shifted % cell_edge;
        if (2 * rem > cell_edge)
            quot++;
        return quot;
    endfunction

    function automatic ppdh_out_t predict_beat(input ppdh_in_t beat);
        ppdh_out_t       res;
        longint          x, y, lim, ax, ay;
        longint unsigned col, row;
        bin_addr_t       hit;
        res = '0;
        if (beat.command == CMD_READ) begin
            res.column = beat.read_column;
            res.row    = beat.read_row;
            if (beat.population < NUM_POPS)
                res.count = bin_store[beat.population][beat.read_column][beat.read_row];
            return res;
        end
        x   = $signed(beat.x_position);
        y   = $signed(beat.y_position);
        lim = longint'(box_half) - longint'(cell_edge);
        ax  = (x < 0) ? -x : x;
        ay  = (y < 0) ? -y : y;
        if (cell_edge == 0 || !(ax < lim && ay < lim))
            return res;
        col = grid_index(x);
        row = grid_index(y);
        if (col >= GRID || row >= GRID || beat.population >= NUM_POPS)
            return res;
        if (bin_store[beat.population][col][row] != '1)
            bin_store[beat.population][col][row]++;
        res.binned = 1'b1;
        res.column = 8'(col);
        res.row    = 8'(row);
        res.count  = bin_store[beat.population][col][row];
        hit = '{pop: beat.population, col: 8'(col), row: 8'(row)};
        recent_hits = {recent_hits, hit};
        if (recent_hits.size() > RECENT_DEPTH)
            void'(recent_hits.pop_front());
        return res;
    endfunction

    function automatic int unsigned idle_length();
        return ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3, 1);
    endfunction

    function automatic int unsigned idle_gap();
        if (no_idle || $urandom_range(1) == 0)
            return 0;
        return idle_length();
    endfunction

    // coordinate near a cell boundary or centre of the current grid
    function automatic logic [POS_W-1:0] aimed_coord();
        longint span, pos, offset;
        span = (cell_edge == 0) ? 64'd65536 : longint'(cell_edge);
        pos  = longint'($urandom_range(GRID + 4)) * span - longint'(box_half);
        case ($urandom_range(7))
            0:       offset = span / 2;
            1:       offset = span / 2 + 1;
            2:       offset = -(span / 2);
            default: offset = longint'($urandom_range(32'(span))) - span / 2;
        endcase
        pos = pos + offset;
        if (pos > POS_MAX)
            pos = POS_MAX;
        if (pos < POS_MIN)
            pos = POS_MIN;
        return pos[POS_W-1:0];
    endfunction

    function automatic ppdh_in_t random_beat();
        ppdh_in_t  beat;
        bin_addr_t pick;
        beat.command     = ($urandom_range(9) < 3) ? CMD_READ : CMD_BIN;
        beat.x_position  = aimed_coord();
        beat.y_position  = aimed_coord();
        beat.population  = ($urandom_range(11) == 0) ? 2'd3 : 2'($urandom_range(2));
        beat.read_column = 8'($urandom);
        beat.read_row    = 8'($urandom);
        if ($urandom_range(7) == 0) begin
            beat.x_position = $urandom;
            beat.y_position = $urandom;
        end
        if (beat.command == CMD_READ && recent_hits.size() != 0 && $urandom_range(3) != 0) begin
            pick             = recent_hits[$urandom_range(recent_hits.size() - 1)];
            beat.population  = pick.pop;
            beat.read_column = pick.col;
            beat.read_row    = pick.row;
        end
        return beat;
    endfunction

    task automatic add_row(input logic cmd, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [1:0] pop, input logic [7:0] col, input logic [7:0] row,
                           input bit typed, input logic want_binned, input logic [7:0] want_col,
                           input logic [7:0] want_row, input logic [31:0] want_count);
        stim_row_t entry;
        entry.beat   = '{command: cmd, x_position: x, y_position: y, population: pop,
                         read_column: col, read_row: row};
        entry.typed  = typed;
        entry.result = '{binned: want_binned, column: want_col, row: want_row,
                         count: want_count};
        directed_rows = {directed_rows, entry};
    endtask

    task automatic send_beat(input ppdh_in_t beat, input bit typed, input ppdh_out_t typed_result);
        int unsigned gap;
        ppdh_out_t   predicted;
        gap = idle_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_beat(beat);
        expected_results = {expected_results, (typed ? typed_result : predicted)};
        beats_sent++;
        if (beat.command == CMD_READ)
            reads_sent++;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_beat(random_beat(), PREDICTED, '0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_HALF_BOX)
            box_half = data[CFG_W-1:0];
        else if (idx == CFG_CELL_SIZE)
            cell_edge = data[CFG_W-1:0];
    endtask

    // top data bit is dropped by the block; an unused index is written in between
    task automatic load_settings(input logic [CFG_W-1:0] box, input logic [CFG_W-1:0] cell_len);
        cfg_beat(CFG_HALF_BOX, {1'($urandom_range(1)), box});
        cfg_beat(CFG_IDX_W'(CFG_CELL_SIZE + 1 + $urandom_range(13)), $urandom);
        cfg_beat(CFG_CELL_SIZE, {1'($urandom_range(1)), cell_len});
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!no_idle && $urandom_range(3) == 0) begin
            stall_left <= idle_length() - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin : result_check
        ppdh_out_t want;
        if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, m_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                errors += check_field("binned", want.binned, m_data.binned);
                errors += check_field("column", want.column, m_data.column);
                errors += check_field("row", want.row, m_data.row);
                errors += check_field("count", want.count, m_data.count);
                results_checked++;
                if (m_data.binned)
                    bins_seen++;
            end
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: half box 100.0, cell 1.0, so the limit is 99.0
        add_row(CMD_READ, 0, 0, 0, 0, 0, TYPED, 0, 0, 0, 0);
        add_row(CMD_READ, 0, 0, 2, 255, 255, TYPED, 0, 255, 255, 0);
        add_row(CMD_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 3, 17, 200, TYPED, 0, 17, 200, 0);
        add_row(CMD_BIN, 0, 0, 0, 0, 0, TYPED, 1, 100, 100, 1);
        add_row(CMD_BIN, 0, 0, 0, 8'hFF, 8'hFF, TYPED, 1, 100, 100, 2);
        add_row(CMD_READ, 0, 0, 0, 100, 100, TYPED, 0, 100, 100, 2);
        add_row(CMD_BIN, 0, 0, 3, 0, 0, TYPED, 0, 0, 0, 0);
        add_row(CMD_BIN, 32'h7FFFFFFF, 0, 0, 0, 0, TYPED, 0, 0, 0, 0);
        add_row(CMD_BIN, 0, 32'h80000000, 1, 0, 0, TYPED, 0, 0, 0, 0);
        add_row(CMD_BIN, 32'h80000000, 32'h7FFFFFFF, 2, 0, 0, TYPED, 0, 0, 0, 0);
        add_row(CMD_BIN, 32'd6488064, 0, 0, 0, 0, TYPED, 0, 0, 0, 0);
        add_row(CMD_BIN, 0, -32'sd6488064, 0, 0, 0, TYPED, 0, 0, 0, 0);
        add_row(CMD_BIN, 32'd6488063, -32'sd6488063, 1, 0, 0, PREDICTED, 0, 0, 0, 0);
        add_row(CMD_BIN, -32'sd6488063, 32'd6488063, 1, 0, 0, PREDICTED, 0, 0, 0, 0);
        add_row(CMD_BIN, 32'd32768, 32'd32768, 2, 0, 0, PREDICTED, 0, 0, 0, 0);
        add_row(CMD_BIN, 32'd32769, -32'sd32769, 2, 0, 0, PREDICTED, 0, 0, 0, 0);
        add_row(CMD_BIN, -32'sd32768, 32'hFFFFFFFF, 0, 0, 0, PREDICTED, 0, 0, 0, 0);
        add_row(CMD_READ, 0, 0, 1, 199, 1, PREDICTED, 0, 0, 0, 0);
        add_row(CMD_READ, 0, 0, 2, 100, 100, PREDICTED, 0, 0, 0, 0);
        add_row(CMD_READ, 0, 0, 3, 100, 100, TYPED, 0, 100, 100, 0);
        add_row(CMD_READ, 0, 0, 0, 100, 100, TYPED, 0, 100, 100, 2);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);
        send_random(RANDOM_PER_PHASE);

        for (int setting = 0; setting < PLAN_LEN; setting++) begin
            drain_results();
            load_settings(box_plan[setting], cell_plan[setting]);
            no_idle <= (setting % 3 == 1);
            settings_run++;
            send_random(RANDOM_PER_PHASE);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        $display("Sent %0d beats (%0d reads) over %0d register settings;", beats_sent,
                 reads_sent, settings_run);
        $display("checked %0d results, %0d of them bin increments.", results_checked, bins_seen);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("testbench failed");
        $finish;
    end

endmodule
